// ----- rtl/tksd_pkg.sv -----
`default_nettype none
package tksd_pkg;

  localparam logic [7:0] BYTE_ESC    = 8'd27;
  localparam logic [7:0] BYTE_LBRACK = 8'h5B;
  localparam logic [7:0] BYTE_THREE  = 8'h33;
  localparam logic [7:0] BYTE_TILDE  = 8'h7E;
  localparam logic [7:0] BYTE_SEMI   = 8'h3B;
  localparam logic [7:0] BYTE_ZERO   = 8'h30;
  localparam logic [7:0] BYTE_NINE   = 8'h39;
  localparam logic [7:0] BYTE_D      = 8'h44;
  localparam logic [7:0] BYTE_C      = 8'h43;
  localparam logic [7:0] BYTE_A      = 8'h41;
  localparam logic [7:0] BYTE_B      = 8'h42;
  localparam logic [7:0] BYTE_H      = 8'h48;
  localparam logic [7:0] BYTE_F      = 8'h46;

  localparam int QUEUE_AW = 2;

  typedef enum logic [2:0] {
    KIND_PLAIN  = 3'd0,
    KIND_LEFT   = 3'd1,
    KIND_RIGHT  = 3'd2,
    KIND_UP     = 3'd3,
    KIND_DOWN   = 3'd4,
    KIND_HOME   = 3'd5,
    KIND_END    = 3'd6,
    KIND_DELETE = 3'd7
  } key_kind_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_ESC  = 3'd1,
    PH_CSI  = 3'd2,
    PH_CSI3 = 3'd3,
    PH_EAT  = 3'd4
  } phase_t;

  // two: plain ESC first, then plain key_byte
  typedef struct packed {
    logic      two;
    key_kind_t kind;
    logic [7:0] key_byte;
  } cmd_t;

  function automatic logic is_param(input logic [7:0] b);
    return ((b >= BYTE_ZERO) && (b <= BYTE_NINE)) || (b == BYTE_SEMI);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/tksd_if.sv -----
`default_nettype none
interface tksd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface tksd_key_if;
  logic       valid;
  logic       ready;
  logic [2:0] key_kind;
  logic [7:0] key_byte;
  logic       last;

  modport source (output valid, output key_kind, output key_byte, output last, input ready);
  modport sink   (input valid, input key_kind, input key_byte, input last, output ready);
endinterface
`default_nettype wire

// ----- rtl/tksd_front.sv -----
`default_nettype none
module tksd_front #(
  parameter int MAX_SEQ = 10
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic [7:0]  in_byte,
  output logic             in_ready,
  input  wire logic        q_full,
  output logic             push,
  output tksd_pkg::cmd_t   cmd
);

  tksd_pkg::phase_t phase, phase_next;
  logic [3:0]       seq_count, seq_count_next;
  logic             take;
  logic             emit;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;
  assign push     = take && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= tksd_pkg::PH_IDLE;
      seq_count <= 4'd0;
    end else if (take) begin
      phase     <= phase_next;
      seq_count <= seq_count_next;
    end
  end

  always_comb begin
    phase_next     = phase;
    seq_count_next = seq_count;
    emit           = 1'b0;
    cmd.two        = 1'b0;
    cmd.kind       = tksd_pkg::KIND_PLAIN;
    cmd.key_byte   = in_byte;
    unique case (phase)
      tksd_pkg::PH_ESC: begin
        if (in_byte == tksd_pkg::BYTE_LBRACK) begin
          phase_next     = tksd_pkg::PH_CSI;
          seq_count_next = 4'd2;
        end else begin
          emit    = 1'b1;
          cmd.two = (in_byte != tksd_pkg::BYTE_ESC);
          if (in_byte == tksd_pkg::BYTE_ESC) begin
            phase_next     = tksd_pkg::PH_ESC;
            seq_count_next = 4'd1;
          end else begin
            phase_next     = tksd_pkg::PH_IDLE;
            seq_count_next = 4'd0;
          end
        end
      end
      tksd_pkg::PH_CSI: begin
        phase_next     = tksd_pkg::PH_IDLE;
        seq_count_next = 4'd0;
        cmd.key_byte   = 8'd0;
        case (in_byte)
          tksd_pkg::BYTE_D: begin emit = 1'b1; cmd.kind = tksd_pkg::KIND_LEFT;  end
          tksd_pkg::BYTE_C: begin emit = 1'b1; cmd.kind = tksd_pkg::KIND_RIGHT; end
          tksd_pkg::BYTE_A: begin emit = 1'b1; cmd.kind = tksd_pkg::KIND_UP;    end
          tksd_pkg::BYTE_B: begin emit = 1'b1; cmd.kind = tksd_pkg::KIND_DOWN;  end
          tksd_pkg::BYTE_H: begin emit = 1'b1; cmd.kind = tksd_pkg::KIND_HOME;  end
          tksd_pkg::BYTE_F: begin emit = 1'b1; cmd.kind = tksd_pkg::KIND_END;   end
          tksd_pkg::BYTE_THREE: begin
            phase_next     = tksd_pkg::PH_CSI3;
            seq_count_next = 4'd3;
          end
          default: begin
            if (tksd_pkg::is_param(in_byte)) begin
              phase_next     = tksd_pkg::PH_EAT;
              seq_count_next = 4'd3;
            end
          end
        endcase
      end
      tksd_pkg::PH_CSI3: begin
        phase_next     = tksd_pkg::PH_IDLE;
        seq_count_next = 4'd0;
        cmd.key_byte   = 8'd0;
        if (in_byte == tksd_pkg::BYTE_TILDE) begin
          emit     = 1'b1;
          cmd.kind = tksd_pkg::KIND_DELETE;
        end else if (tksd_pkg::is_param(in_byte)) begin
          phase_next     = tksd_pkg::PH_EAT;
          seq_count_next = 4'd4;
        end
      end
      tksd_pkg::PH_EAT: begin
        if (seq_count >= 4'(MAX_SEQ)) begin
          emit = (in_byte != tksd_pkg::BYTE_ESC);
          if (in_byte == tksd_pkg::BYTE_ESC) begin
            phase_next     = tksd_pkg::PH_ESC;
            seq_count_next = 4'd1;
          end else begin
            phase_next     = tksd_pkg::PH_IDLE;
            seq_count_next = 4'd0;
          end
        end else if (tksd_pkg::is_param(in_byte)) begin
          seq_count_next = seq_count + 4'd1;
        end else begin
          phase_next     = tksd_pkg::PH_IDLE;
          seq_count_next = 4'd0;
        end
      end
      default: begin
        emit = (in_byte != tksd_pkg::BYTE_ESC);
        if (in_byte == tksd_pkg::BYTE_ESC) begin
          phase_next     = tksd_pkg::PH_ESC;
          seq_count_next = 4'd1;
        end else begin
          phase_next     = tksd_pkg::PH_IDLE;
          seq_count_next = 4'd0;
        end
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/tksd_queue.sv -----
`default_nettype none
module tksd_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire tksd_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output logic                q_valid,
  output tksd_pkg::cmd_t      head
);

  localparam int AW    = tksd_pkg::QUEUE_AW;
  localparam int DEPTH = 1 << AW;

  tksd_pkg::cmd_t entries [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [AW:0]    count;
  logic           do_push;
  logic           do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign q_valid = (count != '0);
  assign head    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/tksd_back.sv -----
`default_nettype none
module tksd_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire tksd_pkg::cmd_t head,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [2:0]          key_kind,
  output logic [7:0]          key_byte,
  output logic                last
);

  logic half;
  logic load;

  assign load = !out_valid || out_ready;
  assign pop  = load && q_valid && !(head.two && !half);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      half      <= 1'b0;
    end else if (load) begin
      out_valid <= q_valid;
      if (q_valid) begin
        half <= head.two && !half;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && q_valid) begin
      if (head.two && !half) begin
        key_kind <= tksd_pkg::KIND_PLAIN;
        key_byte <= tksd_pkg::BYTE_ESC;
        last     <= 1'b0;
      end else begin
        key_kind <= head.kind;
        key_byte <= head.key_byte;
        last     <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/terminal_key_sequence_decoder.sv -----
// Terminal key sequence decoder.
// rx takes one raw terminal byte per transfer; keys gives decoded keys
// (key_kind, key_byte, last). ESC '[' plus an arrow/home/end letter, or
// ESC '[' '3' '~', gives one key; other CSI sequences are swallowed.
// A stray ESC gives a plain ESC, then the next byte as a plain key unless
// it is ESC, which opens a new sequence; so one byte may give two keys;
// last marks the final key of a byte. Keys pass from the parser through
// the 4-entry queue to the output register. Throughput: one byte per
// cycle while the queue has room; a byte giving two keys holds the output
// stage for both, which the queue absorbs; rx.ready drops only when full.
// When keys is stalled, the output register holds its key and the queue
// fills; the parser keeps taking bytes until the queue is full.
// Reset (rst, synchronous): parser returns to idle, sequence count to
// zero, queue and output stage empty.
// MAX_SEQ: bytes a parameter sequence may take before it is dropped.
`default_nettype none
module terminal_key_sequence_decoder #(
  parameter int MAX_SEQ = 10
) (
  input wire logic   clk,
  input wire logic   rst,
  tksd_byte_if.sink  rx,
  tksd_key_if.source keys
);

  logic           push;
  logic           full;
  logic           pop;
  logic           q_valid;
  tksd_pkg::cmd_t push_cmd;
  tksd_pkg::cmd_t head;

  tksd_front #(.MAX_SEQ(MAX_SEQ)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rx.valid),
    .in_byte  (rx.in_byte),
    .in_ready (rx.ready),
    .q_full   (full),
    .push     (push),
    .cmd      (push_cmd)
  );

  tksd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .q_valid  (q_valid),
    .head     (head)
  );

  tksd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop),
    .out_valid (keys.valid),
    .out_ready (keys.ready),
    .key_kind  (keys.key_kind),
    .key_byte  (keys.key_byte),
    .last      (keys.last)
  );

endmodule
`default_nettype wire
